// ===== rtl/rmj_pkg.sv =====
`default_nettype none
package rmj_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 17;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

  localparam int PROD_W   = 2 * DATA_W;          // one 32x32 product
  localparam int SQ_W     = 2 * DATA_W;          // squared range
  localparam int ROOT_W   = SQ_W / 2;            // range
  localparam int R3_W     = SQ_W + ROOT_W;       // range cubed
  localparam int NUM_W    = R3_W + FRAC_W;       // widest numerator magnitude
  localparam int DEN_W    = R3_W;                // widest divisor
  localparam int Q_W      = DATA_W;              // quotient bits produced
  localparam int CMP_W    = DEN_W + Q_W;

  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = Q_W + 2;
  localparam int PIPE_LAT = 2 + SQRT_LAT + 2 + DIV_LAT;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic [SQ_W-1:0]          r2;
    logic                     tneg;
    logic [SQ_W-1:0]          tmag;
  } carry_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drange_dpx;
    logic signed [DATA_W-1:0] drange_dpy;
    logic signed [DATA_W-1:0] dbearing_dpx;
    logic signed [DATA_W-1:0] dbearing_dpy;
    logic signed [DATA_W-1:0] drate_dpx;
    logic signed [DATA_W-1:0] drate_dpy;
  } out_res_t;

endpackage
`default_nettype wire

// ===== rtl/rmj_in_if.sv =====
`default_nettype none
interface rmj_in_if;
  import rmj_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/rmj_out_if.sv =====
`default_nettype none
interface rmj_out_if;
  import rmj_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drange_dpx;
  logic signed [DATA_W-1:0] drange_dpy;
  logic signed [DATA_W-1:0] dbearing_dpx;
  logic signed [DATA_W-1:0] dbearing_dpy;
  logic signed [DATA_W-1:0] drate_dpx;
  logic signed [DATA_W-1:0] drate_dpy;
  modport source (output valid, output drange_dpx, output drange_dpy,
                  output dbearing_dpx, output dbearing_dpy, output drate_dpx,
                  output drate_dpy, input ready);
  modport sink (input valid, input drange_dpx, input drange_dpy,
                input dbearing_dpx, input dbearing_dpy, input drate_dpx,
                input drate_dpy, output ready);
endinterface
`default_nettype wire

// ===== rtl/rmj_sqrt.sv =====
`default_nettype none
// Pipelined integer square root, one root bit per stage.
module rmj_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rmj_pkg::SQ_W-1:0]    rad,
  output logic [rmj_pkg::ROOT_W-1:0]  root
);
  import rmj_pkg::*;

  localparam int T_W = SQ_W + 2;

  logic [SQ_W-1:0]   rem_w [0:ROOT_W];
  logic [ROOT_W-1:0] res_w [0:ROOT_W];
  logic [SQ_W-1:0]   rem_r [0:ROOT_W-1];
  logic [ROOT_W-1:0] res_r [0:ROOT_W-1];

  assign rem_w[0] = rad;
  assign res_w[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [T_W-1:0] trial;
    logic           take;

    // (res + 2^B)^2 - res^2
    assign trial = (T_W'(res_w[k]) << (B + 1)) | (T_W'(1) << (2 * B));
    assign take  = T_W'(rem_w[k]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? rem_w[k] - SQ_W'(trial) : rem_w[k];
        res_r[k] <= take ? res_w[k] | (ROOT_W'(1) << B) : res_w[k];
      end
    end

    assign rem_w[k+1] = rem_r[k];
    assign res_w[k+1] = res_r[k];
  end

  assign root = res_w[ROOT_W];

endmodule
`default_nettype wire

// ===== rtl/rmj_div.sv =====
`default_nettype none
// Pipelined restoring divider: overflow check, one quotient bit per stage,
// then signed saturation.
module rmj_div (
  input  logic                             clk,
  input  logic                             en,
  input  rmj_pkg::div_req_t                req,
  output logic signed [rmj_pkg::DATA_W-1:0] quo
);
  import rmj_pkg::*;

  logic [NUM_W-1:0] rem_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];
  logic             ovf_r [0:Q_W];
  logic             neg_r [0:Q_W];

  // quotient would need more than Q_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= CMP_W'(req.num) >= {req.den, {Q_W{1'b0}}};
      rem_r[0] <= req.num;
      den_r[0] <= req.den;
      neg_r[0] <= req.neg;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int B = Q_W - 1 - k;
    logic [CMP_W-1:0] trial;
    logic             take;

    assign trial = CMP_W'(den_r[k]) << B;
    assign take  = CMP_W'(rem_r[k]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? rem_r[k] - NUM_W'(trial) : rem_r[k];
        q_r[k+1]   <= take ? q_r[k] | (Q_W'(1) << B) : q_r[k];
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  logic [Q_W-1:0]          q_fin;
  logic signed [DATA_W-1:0] sat;

  assign q_fin = q_r[Q_W];

  always_comb begin
    if (neg_r[Q_W]) begin
      if (ovf_r[Q_W] || (q_fin[Q_W-1] && (q_fin[Q_W-2:0] != '0))) sat = SAT_MIN;
      else                                                         sat = -q_fin;
    end else begin
      if (ovf_r[Q_W] || q_fin[Q_W-1]) sat = SAT_MAX;
      else                            sat = q_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo <= sat;
  end

endmodule
`default_nettype wire

// ===== rtl/radar_measurement_jacobian_unit.sv =====
`default_nettype none
// Radar measurement Jacobian, fully pipelined.
// An accepted request passes 70 pipe stages, then the output register; the 32-stage root
// and the 32-step dividers set depth. Throughput: one request per cycle unless stalled.
// A two-entry output (register plus skid) stalls the pipe only when both are full.
// Reset (sync, active low) clears valid bits and sets the floor register cfg_r to 1.
module radar_measurement_jacobian_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rmj_pkg::CFG_W-1:0]   cfg_wdata,
  rmj_in_if.sink                      in_chan,
  rmj_out_if.source                   out_chan
);
  import rmj_pkg::*;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n)      cfg_r <= CFG_RESET;
    else if (cfg_we) cfg_r <= cfg_wdata;
  end

  // zero floor behaves as one
  logic [CFG_W-1:0] floor_m;
  logic [SQ_W-1:0]  floor_v;
  assign floor_m = (cfg_r == '0) ? CFG_W'(1) : cfg_r;
  assign floor_v = SQ_W'({floor_m, {FRAC_W{1'b0}}});

  // --------------------------------------------------------- flow control
  // Whole pipe advances together; the skid entry absorbs one result while
  // the output register waits.
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  logic                skid_v_r;
  logic                out_v_r;

  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n)  vld_r <= '0;
    else if (en) vld_r <= {vld_r[PIPE_LAT-2:0], in_chan.valid};
  end

  // ------------------------------------------------- stage 1: products
  logic signed [PROD_W-1:0] pxx_r, pyy_r, vxpy_r, vypx_r;
  logic signed [DATA_W-1:0] px1_r, py1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r  <= in_chan.pos_x * in_chan.pos_x;
      pyy_r  <= in_chan.pos_y * in_chan.pos_y;
      vxpy_r <= in_chan.vel_x * in_chan.pos_y;
      vypx_r <= in_chan.vel_y * in_chan.pos_x;
      px1_r  <= in_chan.pos_x;
      py1_r  <= in_chan.pos_y;
    end
  end

  // ---------------------------------- stage 2: clamped r2, cross term t
  logic [SQ_W-1:0]          r2_sum;
  logic signed [PROD_W:0]   t_full;
  logic [PROD_W:0]          t_abs;
  carry_t                   c2_r;

  assign r2_sum = SQ_W'(pxx_r) + SQ_W'(pyy_r);
  assign t_full = {vxpy_r[PROD_W-1], vxpy_r} - {vypx_r[PROD_W-1], vypx_r};
  assign t_abs  = t_full[PROD_W] ? -t_full : t_full;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r.px   <= px1_r;
      c2_r.py   <= py1_r;
      c2_r.r2   <= (r2_sum < floor_v) ? floor_v : r2_sum;
      c2_r.tneg <= t_full[PROD_W];
      c2_r.tmag <= t_abs[SQ_W-1:0];
    end
  end

  // ------------------------------------------------ range = isqrt(r2)
  logic [ROOT_W-1:0] root;
  carry_t            dl_r [0:SQRT_LAT-1];

  rmj_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (c2_r.r2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= c2_r;
      for (int i = 1; i < SQRT_LAT; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  // --------------------------------------- stage 3: partial products
  carry_t             c3;
  logic [DATA_W-1:0]  pxm, pym;
  logic [PROD_W-1:0]  p_r2lo_r, p_r2hi_r, p_ylo_r, p_yhi_r, p_xlo_r, p_xhi_r;
  logic [DATA_W-1:0]  pxm3_r, pym3_r;
  logic [ROOT_W-1:0]  r3root_r;
  logic [SQ_W-1:0]    r2_3_r;
  logic               sx3_r, sy3_r, tneg3_r;

  assign c3  = dl_r[SQRT_LAT-1];
  assign pxm = c3.px[DATA_W-1] ? DATA_W'(-c3.px) : DATA_W'(c3.px);
  assign pym = c3.py[DATA_W-1] ? DATA_W'(-c3.py) : DATA_W'(c3.py);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r2lo_r <= PROD_W'(c3.r2[SQ_W/2-1:0]) * PROD_W'(root);
      p_r2hi_r <= PROD_W'(c3.r2[SQ_W-1:SQ_W/2]) * PROD_W'(root);
      p_ylo_r  <= PROD_W'(pym) * PROD_W'(c3.tmag[SQ_W/2-1:0]);
      p_yhi_r  <= PROD_W'(pym) * PROD_W'(c3.tmag[SQ_W-1:SQ_W/2]);
      p_xlo_r  <= PROD_W'(pxm) * PROD_W'(c3.tmag[SQ_W/2-1:0]);
      p_xhi_r  <= PROD_W'(pxm) * PROD_W'(c3.tmag[SQ_W-1:SQ_W/2]);
      pxm3_r   <= pxm;
      pym3_r   <= pym;
      r3root_r <= root;
      r2_3_r   <= c3.r2;
      sx3_r    <= c3.px[DATA_W-1];
      sy3_r    <= c3.py[DATA_W-1];
      tneg3_r  <= c3.tneg;
    end
  end

  // ----------------------------- stage 4: sums, divider requests
  logic [R3_W-1:0] r3_sum, ny_sum, nx_sum;
  div_req_t        req_r [0:5];

  assign r3_sum = {p_r2hi_r, {(SQ_W/2){1'b0}}} + R3_W'(p_r2lo_r);
  assign ny_sum = {p_yhi_r, {(SQ_W/2){1'b0}}} + R3_W'(p_ylo_r);
  assign nx_sum = {p_xhi_r, {(SQ_W/2){1'b0}}} + R3_W'(p_xlo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // px / r, py / r
      req_r[0] <= '{num: NUM_W'({pxm3_r, {FRAC_W{1'b0}}}), den: DEN_W'(r3root_r),
                    neg: sx3_r};
      req_r[1] <= '{num: NUM_W'({pym3_r, {FRAC_W{1'b0}}}), den: DEN_W'(r3root_r),
                    neg: sy3_r};
      // -py / r2, px / r2
      req_r[2] <= '{num: NUM_W'({pym3_r, {(2*FRAC_W){1'b0}}}), den: DEN_W'(r2_3_r),
                    neg: !sy3_r};
      req_r[3] <= '{num: NUM_W'({pxm3_r, {(2*FRAC_W){1'b0}}}), den: DEN_W'(r2_3_r),
                    neg: sx3_r};
      // py t / r^3, -px t / r^3
      req_r[4] <= '{num: {ny_sum, {FRAC_W{1'b0}}}, den: r3_sum,
                    neg: sy3_r ^ tneg3_r};
      req_r[5] <= '{num: {nx_sum, {FRAC_W{1'b0}}}, den: r3_sum,
                    neg: !(sx3_r ^ tneg3_r)};
    end
  end

  // ---------------------------------------------------------- dividers
  logic signed [DATA_W-1:0] quo [0:5];

  for (genvar d = 0; d < 6; d++) begin : g_div
    rmj_div u_div (
      .clk (clk),
      .en  (en),
      .req (req_r[d]),
      .quo (quo[d])
    );
  end

  out_res_t pipe_res;
  assign pipe_res = '{drange_dpx: quo[0], drange_dpy: quo[1], dbearing_dpx: quo[2],
                      dbearing_dpy: quo[3], drate_dpx: quo[4], drate_dpy: quo[5]};

  // ------------------------------------------------- output + skid
  out_res_t out_r, skid_r;
  logic     pop, pv;

  assign pv  = vld_r[PIPE_LAT-1];
  assign pop = out_v_r && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || pop) begin
      out_v_r <= pv;
    end else begin
      skid_v_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) out_r <= skid_r;
    end else if (!out_v_r || pop) begin
      out_r <= pipe_res;
    end else begin
      skid_r <= pipe_res;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.drange_dpx   = out_r.drange_dpx;
  assign out_chan.drange_dpy   = out_r.drange_dpy;
  assign out_chan.dbearing_dpx = out_r.dbearing_dpx;
  assign out_chan.dbearing_dpy = out_r.dbearing_dpy;
  assign out_chan.drate_dpx    = out_r.drate_dpx;
  assign out_chan.drate_dpy    = out_r.drate_dpy;

endmodule
`default_nettype wire

// ===== tb/sv/radar_measurement_jacobian_unit_tb.sv =====
module radar_measurement_jacobian_unit_tb;
  import rmj_pkg::*;

  typedef logic signed [255:0] wide_t;

  // ---------------------------------------------------------------------
  // Scoreboard: predicts the Jacobian for each accepted request and holds
  // the expected results in request order.
  // ---------------------------------------------------------------------
  class jacobian_scoreboard;
    out_res_t         expected_jac_q[$];
    logic [CFG_W-1:0] floor_sq;
    int               errors;
    int               n_checked;

    function new();
      floor_sq  = CFG_RESET;
      errors    = 0;
      n_checked = 0;
    endfunction

    function void report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endfunction

    function logic [63:0] range_root(wide_t v);
      logic [63:0] res;
      logic [63:0] cand;
      wide_t       c;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        c = {192'd0, cand};
        if (c * c <= v) res = cand;
      end
      return res;
    endfunction

    // truncating divide, then clamp to the signed data range
    function logic signed [DATA_W-1:0] sat_div(wide_t num, wide_t den);
      wide_t q;
      wide_t hi;
      wide_t lo;
      hi = SAT_MAX;
      lo = SAT_MIN;
      q = num / den;
      if (q > hi) return SAT_MAX;
      if (q < lo) return SAT_MIN;
      return q[DATA_W-1:0];
    endfunction

    function out_res_t predict_jacobian(logic signed [DATA_W-1:0] pos_x,
                                        logic signed [DATA_W-1:0] pos_y,
                                        logic signed [DATA_W-1:0] vel_x,
                                        logic signed [DATA_W-1:0] vel_y);
      wide_t            px, py, vx, vy, r2, fl, r, r3, t;
      logic [CFG_W-1:0] m;
      out_res_t         res;
      px = pos_x;
      py = pos_y;
      vx = vel_x;
      vy = vel_y;
      m  = (floor_sq == 0) ? CFG_W'(1) : floor_sq;
      fl = {239'd0, m};
      fl = fl << FRAC_W;
      r2 = px * px + py * py;
      if (r2 < fl) r2 = fl;
      r  = {192'd0, range_root(r2)};
      r3 = r2 * r;
      t  = vx * py - vy * px;
      res.drange_dpx   = sat_div(px <<< FRAC_W, r);
      res.drange_dpy   = sat_div(py <<< FRAC_W, r);
      res.dbearing_dpx = sat_div((-py) <<< (2 * FRAC_W), r2);
      res.dbearing_dpy = sat_div(px <<< (2 * FRAC_W), r2);
      res.drate_dpx    = sat_div((py * t) <<< FRAC_W, r3);
      res.drate_dpy    = sat_div((-(px * t)) <<< FRAC_W, r3);
      return res;
    endfunction

    function void note_request(logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
                               logic signed [DATA_W-1:0] vx, logic signed [DATA_W-1:0] vy);
      expected_jac_q.push_back(predict_jacobian(px, py, vx, vy));
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (expected_jac_q.size() == 0) begin
        errors++;
        $display("unexpected result request: %h", got);
        return;
      end
      want = expected_jac_q.pop_front();
      n_checked++;
      if (got.drange_dpx !== want.drange_dpx)
        report("drange_dpx", got.drange_dpx, want.drange_dpx);
      if (got.drange_dpy !== want.drange_dpy)
        report("drange_dpy", got.drange_dpy, want.drange_dpy);
      if (got.dbearing_dpx !== want.dbearing_dpx)
        report("dbearing_dpx", got.dbearing_dpx, want.dbearing_dpx);
      if (got.dbearing_dpy !== want.dbearing_dpy)
        report("dbearing_dpy", got.dbearing_dpy, want.dbearing_dpy);
      if (got.drate_dpx !== want.drate_dpx)
        report("drate_dpx", got.drate_dpx, want.drate_dpx);
      if (got.drate_dpy !== want.drate_dpy)
        report("drate_dpy", got.drate_dpy, want.drate_dpy);
    endfunction
  endclass

  // margin left after the drain, before a register write
  localparam int SETTLE_CYC   = 90;
  // longest legal quiet stretch is a drain plus settle plus a stall: far below this
  localparam int WATCHDOG_LIM = 3000;
  localparam int N_PHASE      = 5;
  localparam int ITEMS_PHASE  = 390;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rmj_in_if  in_if ();
  rmj_out_if out_if ();

  radar_measurement_jacobian_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  jacobian_scoreboard jac_sb = new();

  int n_sent;
  int n_cfg;
  int quiet_cyc;
  int rcv_cyc;
  int stall_left;
  int burst_left;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Receiver: ready pattern rotates through four modes - always ready,
  // random drops, a fixed duty pattern, and occasional long stalls.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rcv_cyc <= rcv_cyc + 1;
    case ((rcv_cyc / 500) % 4)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        out_if.ready <= ((rcv_cyc % 7) < 4);
      end
      default: begin
        if (stall_left > 0) begin
          out_if.ready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_if.ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Result monitor: sample pre-edge values, so the accepted request is exact.
  always @(posedge clk) begin
    out_res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.drange_dpx   = out_if.drange_dpx;
      got.drange_dpy   = out_if.drange_dpy;
      got.dbearing_dpx = out_if.dbearing_dpx;
      got.dbearing_dpy = out_if.dbearing_dpy;
      got.drate_dpx    = out_if.drate_dpx;
      got.drate_dpy    = out_if.drate_dpy;
      jac_sb.check_result(got);
    end
  end

  // Watchdog: any accepted request on either channel resets the quiet count.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= WATCHDOG_LIM) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIM);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // All driving tasks start and end right after a rising edge.
  task automatic send_item(logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
                           logic signed [DATA_W-1:0] vx, logic signed [DATA_W-1:0] vy);
    in_if.valid <= 1'b1;
    in_if.pos_x <= px;
    in_if.pos_y <= py;
    in_if.vel_x <= vx;
    in_if.vel_y <= vy;
    do @(posedge clk); while (!in_if.ready);
    jac_sb.note_request(px, py, vx, vy);
    n_sent++;
  endtask

  // Burst/gap shaping after each accepted request.
  task automatic sender_gap();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 40);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until the pipe is empty, then let it settle.
  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (jac_sb.expected_jac_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_floor(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    jac_sb.floor_sq = v;
    n_cfg++;
  endtask

  // Mix of magnitudes: full range, moderate, tiny (may be below floor), extremes.
  function automatic logic signed [DATA_W-1:0] rand_field();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom);
      1: return DATA_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return DATA_W'($signed($urandom_range(0, 1024)) - 512);
      default: return ($urandom_range(0, 1)) ? SAT_MAX - DATA_W'($urandom_range(0, 3)) :
                                              SAT_MIN + DATA_W'($urandom_range(0, 3));
    endcase
  endfunction

  logic [CFG_W-1:0] phase_floor[N_PHASE];

  initial begin
    in_if.valid  = 1'b0;
    in_if.pos_x  = '0;
    in_if.pos_y  = '0;
    in_if.vel_x  = '0;
    in_if.vel_y  = '0;
    out_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    n_sent       = 0;
    n_cfg        = 0;
    quiet_cyc    = 0;
    rcv_cyc      = 0;
    stall_left   = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;

    phase_floor[0] = 17'd0;        // zero floor acts as one
    phase_floor[1] = 17'd65536;
    phase_floor[2] = 17'h1FFFF;    // widest value the port carries
    phase_floor[3] = CFG_W'($urandom_range(2, 65535));
    phase_floor[4] = 17'd1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset floor: origin, extremes, saturation.
    send_item(0, 0, 0, 0);
    send_item(SAT_MAX, 0, 0, 0);
    send_item(SAT_MIN, 0, 0, 0);
    send_item(0, SAT_MAX, 0, 0);
    send_item(0, SAT_MIN, 0, 0);
    send_item(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    send_item(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    send_item(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX);
    send_item(1, 0, SAT_MAX, SAT_MIN);        // tiny range, huge velocity
    send_item(0, -1, SAT_MIN, SAT_MAX);
    send_item(1, 1, 1, -1);
    send_item(32'h0001_0000, 0, 0, 32'h0001_0000);
    send_item(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, -32'sh0002_0000);
    send_item(-32'sh0000_8000, 32'h0000_8000, SAT_MAX, SAT_MAX);
    send_item(32'h0000_0100, -32'sh0000_0100, SAT_MIN, 0);
    send_item(-1, -1, -1, -1);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    drain_pipe();

    for (int ph = 0; ph < N_PHASE; ph++) begin
      write_floor(phase_floor[ph]);
      no_gaps = (ph == 2);
      if (ph == 0) begin
        send_item(0, 0, SAT_MAX, SAT_MIN);
        send_item(1, -1, 0, 0);
      end
      for (int i = 0; i < ITEMS_PHASE; i++) begin
        send_item(rand_field(), rand_field(), rand_field(), rand_field());
        // one mid-phase pause until every expected result is back
        if (ph == 1 && i == ITEMS_PHASE / 2) begin
          in_if.valid <= 1'b0;
          while (jac_sb.expected_jac_q.size() != 0) @(posedge clk);
        end else begin
          sender_gap();
        end
      end
      drain_pipe();
    end

    $display("sent %0d state vectors, checked %0d Jacobians, %0d floor writes",
             n_sent, jac_sb.n_checked, n_cfg);
    $display("floors covered zero, one, 2^16, 17-bit max and a random value");
    if (jac_sb.errors == 0 && jac_sb.expected_jac_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results outstanding", jac_sb.errors,
               jac_sb.expected_jac_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
